// ----- src/slr_pkg.sv -----
`timescale 1ns / 1ps

package slr_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_STD   = 8'h74;  // t
  localparam logic [7:0] CH_EXT   = 8'h54;  // T
  localparam logic [7:0] CH_RSTD  = 8'h72;  // r
  localparam logic [7:0] CH_REXT  = 8'h52;  // R
  localparam logic [3:0] MAX_DLC  = 4'd8;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_RESP  = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] frame_id;
    logic        extended;
    logic        remote;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [7:0]  resp_byte;
    logic        last;
  } result_t;

  // {ok, nibble}; ok is low when the byte is no hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- src/slcan_line_receiver_top.sv -----
`timescale 1ns / 1ps

// Serial-line CAN receive decoder. Bytes enter one per transaction and are
// kept in a 64-entry line store (63 usable; extra bytes are dropped, but CR
// or BEL still ends the line). An ordinary byte is written into the store. A
// terminator starts a walk over the stored line through the store's single
// read port: a t/T/r/R line ending in CR loads one frame result (3 or 8 id
// digits, no data digits for remote frames), or nothing if malformed; any
// other line is echoed, one response transaction per stored byte. Input is
// stalled for the whole walk. Results pass through an output register, so a
// stalled output only holds the walk in place.

module slcan_line_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_frame_id,
  output logic        out_extended,
  output logic        out_remote,
  output logic [3:0]  out_dlc,
  output logic [63:0] out_payload,
  output logic [7:0]  out_resp_byte,
  output logic        out_last
);

  slr_pkg::ram_req_t ram_req;
  slr_pkg::result_t  res;
  slr_pkg::result_t  out_res;
  logic [7:0]        rd_data;
  logic              res_load;
  logic              out_free;

  slr_line_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  slr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .ram_req    (ram_req),
    .rd_data    (rd_data),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res)
  );

  slr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind      = out_res.kind;
  assign out_frame_id  = out_res.frame_id;
  assign out_extended  = out_res.extended;
  assign out_remote    = out_res.remote;
  assign out_dlc       = out_res.dlc;
  assign out_payload   = out_res.payload;
  assign out_resp_byte = out_res.resp_byte;
  assign out_last      = out_res.last;

endmodule

// ----- src/slr_line_ram.sv -----
`timescale 1ns / 1ps

module slr_line_ram (
  input  logic                     clk,
  input  slr_pkg::ram_req_t        req,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [slr_pkg::LINE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/slr_out_stage.sv -----
`timescale 1ns / 1ps

module slr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  slr_pkg::result_t  res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output slr_pkg::result_t  out_res
);

  logic             valid_r;
  slr_pkg::result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ----- src/slr_ctrl.sv -----
`timescale 1ns / 1ps

module slr_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output slr_pkg::ram_req_t              ram_req,
  input  logic [7:0]                     rd_data,
  input  logic                           out_free,
  output logic                           res_load,
  output slr_pkg::result_t               res
);

  localparam int AW = slr_pkg::ADDR_W;
  localparam logic [AW-1:0] FILL_MAX = AW'(slr_pkg::LINE_DEPTH - 1);

  typedef enum logic [2:0] {S_IDLE, S_HRD, S_RD, S_HEAD, S_FRM, S_RSP, S_FOUT} state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   n_r, n_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   id_end_r, id_end_nxt;
  logic [AW-1:0]   end_r, end_nxt;
  logic            is_cr_r, is_cr_nxt;
  logic            rsp_r, rsp_nxt;
  logic            ext_r, ext_nxt;
  logic            rtr_r, rtr_nxt;
  logic [31:0]     id_r, id_nxt;
  logic [3:0]      dlc_r, dlc_nxt;
  logic [63:0]     data_r, data_nxt;

  logic            accept;
  logic            store;
  logic [AW-1:0]   n_now;
  logic [4:0]      hx;
  logic [3:0]      nib;
  logic [5:0]      nib_off;
  logic            head_frame;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign store    = (fill_r < FILL_MAX);
  assign n_now    = store ? fill_r + AW'(1) : fill_r;
  assign hx       = slr_pkg::hex_digit(rd_data);
  assign nib      = 4'(pos_r - id_end_r - AW'(1));
  // byte i high digit at 8i+4, low digit at 8i
  assign nib_off  = {nib[3:1], ~nib[0], 2'b00};
  assign head_frame = (rd_data == slr_pkg::CH_STD) || (rd_data == slr_pkg::CH_EXT) ||
                      (rd_data == slr_pkg::CH_RSTD) || (rd_data == slr_pkg::CH_REXT);

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    n_nxt      = n_r;
    pos_nxt    = pos_r;
    id_end_nxt = id_end_r;
    end_nxt    = end_r;
    is_cr_nxt  = is_cr_r;
    rsp_nxt    = rsp_r;
    ext_nxt    = ext_r;
    rtr_nxt    = rtr_r;
    id_nxt     = id_r;
    dlc_nxt    = dlc_r;
    data_nxt   = data_r;

    ram_req         = '0;
    ram_req.wr_addr = fill_r;
    ram_req.wr_data = in_rx_byte;
    ram_req.rd_addr = pos_r;

    res_load      = 1'b0;
    res           = '0;
    res.resp_byte = rd_data;
    res.last      = (pos_r == n_r - AW'(1));

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ram_req.wr_en = store;
          fill_nxt      = n_now;
          if (in_rx_byte == slr_pkg::CH_CR || in_rx_byte == slr_pkg::CH_BEL) begin
            n_nxt     = n_now;
            is_cr_nxt = (in_rx_byte == slr_pkg::CH_CR);
            fill_nxt  = '0;
            pos_nxt   = '0;
            state_nxt = S_HRD;
          end
        end
      end
      S_HRD: begin
        // terminator write has landed; fetch the head byte
        ram_req.rd_en = 1'b1;
        state_nxt     = S_HEAD;
      end
      S_HEAD: begin
        if (is_cr_r && n_r > AW'(2) && head_frame) begin
          rsp_nxt    = 1'b0;
          ext_nxt    = (rd_data == slr_pkg::CH_EXT) || (rd_data == slr_pkg::CH_REXT);
          rtr_nxt    = (rd_data == slr_pkg::CH_RSTD) || (rd_data == slr_pkg::CH_REXT);
          id_end_nxt = ((rd_data == slr_pkg::CH_EXT) || (rd_data == slr_pkg::CH_REXT)) ?
                       AW'(9) : AW'(4);
          end_nxt    = '1;
          id_nxt     = '0;
          dlc_nxt    = '0;
          data_nxt   = '0;
          pos_nxt    = AW'(1);
          state_nxt  = S_RD;
        end else begin
          rsp_nxt   = 1'b1;
          state_nxt = S_RSP;
        end
      end
      S_RD: begin
        if (rsp_r) begin
          ram_req.rd_en = 1'b1;
          state_nxt     = S_RSP;
        end else if (pos_r == n_r) begin
          state_nxt = S_IDLE;  // line ran out before the frame was complete
        end else if (pos_r == end_r) begin
          state_nxt = S_FOUT;
        end else begin
          ram_req.rd_en = 1'b1;
          state_nxt     = S_FRM;
        end
      end
      S_FRM: begin
        pos_nxt   = pos_r + AW'(1);
        state_nxt = S_RD;
        if (pos_r < id_end_r) begin
          if (!hx[4]) state_nxt = S_IDLE;
          id_nxt = {id_r[27:0], hx[3:0]};
        end else if (pos_r == id_end_r) begin
          if (!hx[4] || hx[3:0] > slr_pkg::MAX_DLC) state_nxt = S_IDLE;
          dlc_nxt = hx[3:0];
          end_nxt = rtr_r ? id_end_r + AW'(1) :
                    id_end_r + AW'(1) + AW'({hx[3:0], 1'b0});
        end else begin
          if (!hx[4]) state_nxt = S_IDLE;
          data_nxt[nib_off +: 4] = hx[3:0];
        end
      end
      S_RSP: begin
        if (out_free) begin
          res_load  = 1'b1;
          res.kind  = slr_pkg::KIND_RESP;
          pos_nxt   = pos_r + AW'(1);
          state_nxt = res.last ? S_IDLE : S_RD;
        end
      end
      S_FOUT: begin
        if (out_free) begin
          res_load      = 1'b1;
          res.kind      = slr_pkg::KIND_FRAME;
          res.frame_id  = id_r;
          res.extended  = ext_r;
          res.remote    = rtr_r;
          res.dlc       = dlc_r;
          res.payload   = data_r;
          res.resp_byte = '0;
          res.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      rsp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rsp_r   <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    pos_r    <= pos_nxt;
    id_end_r <= id_end_nxt;
    end_r    <= end_nxt;
    is_cr_r  <= is_cr_nxt;
    ext_r    <= ext_nxt;
    rtr_r    <= rtr_nxt;
    id_r     <= id_nxt;
    dlc_r    <= dlc_nxt;
    data_r   <= data_nxt;
  end

endmodule

// ----- tb/slcan_line_receiver_top_tb.sv -----
`timescale 1ns / 1ps

module slcan_line_receiver_top_tb;

  localparam int RANDOM_BYTES   = 280;
  localparam int PRESSURE_AT    = 12;    // results seen before the long hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [31:0] out_frame_id;
  logic        out_extended;
  logic        out_remote;
  logic [3:0]  out_dlc;
  logic [63:0] out_payload;
  logic [7:0]  out_resp_byte;
  logic        out_last;

  slcan_line_receiver_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_frame_id (out_frame_id),
    .out_extended (out_extended),
    .out_remote   (out_remote),
    .out_dlc      (out_dlc),
    .out_payload  (out_payload),
    .out_resp_byte(out_resp_byte),
    .out_last     (out_last)
  );

  // stimulus and expectations
  logic [7:0]       rx_q[$];
  logic [7:0]       line_buf[$];
  slr_pkg::result_t pending_results[$];

  // shadow of the line store
  logic [7:0] line_mem [slr_pkg::LINE_DEPTH];
  int         line_fill = 0;

  int err_cnt   = 0;
  int sent_cnt  = 0;
  int res_seen  = 0;
  int in_gap    = 0;
  int out_wait  = 0;
  bit hold_done = 1'b0;
  int long_lines = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int nib_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 65 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 97 + 10;
    return -1;
  endfunction

  function automatic bit is_frame_head(input logic [7:0] c);
    return (c == slr_pkg::CH_STD) || (c == slr_pkg::CH_EXT) ||
           (c == slr_pkg::CH_RSTD) || (c == slr_pkg::CH_REXT);
  endfunction

  // decode the stored line of n bytes; 0 when malformed
  function automatic bit decode_frame(input int n, output slr_pkg::result_t fr);
    int idx, stop, nb, d, d2;
    logic [7:0] head;
    fr = '0;
    fr.kind = slr_pkg::KIND_FRAME;
    fr.last = 1'b1;
    head = line_mem[0];
    idx = 1;
    nb = 0;
    case (head)
      slr_pkg::CH_STD:  stop = 4;
      slr_pkg::CH_EXT: begin
        stop = 9;
        fr.extended = 1'b1;
      end
      slr_pkg::CH_RSTD: begin
        stop = 4;
        fr.remote = 1'b1;
      end
      slr_pkg::CH_REXT: begin
        stop = 9;
        fr.extended = 1'b1;
        fr.remote = 1'b1;
      end
      default: return 1'b0;
    endcase
    if (idx >= n) return 1'b0;
    while (idx < stop && idx < n) begin
      d = nib_val(line_mem[idx]);
      idx++;
      if (d < 0) return 1'b0;
      fr.frame_id = {fr.frame_id[27:0], d[3:0]};
    end
    if (idx >= n) return 1'b0;
    d = nib_val(line_mem[idx]);
    idx++;
    if (d < 0 || d > int'(slr_pkg::MAX_DLC)) return 1'b0;
    fr.dlc = d[3:0];
    if (idx >= n) return 1'b0;
    stop = fr.remote ? idx : idx + 2 * int'(fr.dlc);
    while (idx < stop && idx < n) begin
      d = nib_val(line_mem[idx]);
      idx++;
      if (d < 0 || idx >= n) return 1'b0;
      d2 = nib_val(line_mem[idx]);
      idx++;
      if (d2 < 0) return 1'b0;
      fr.payload[8*(nb%8) +: 8] = {d[3:0], d2[3:0]};
      nb++;
    end
    if (idx >= n) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void echo_line(input int n);
    slr_pkg::result_t r;
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.kind = slr_pkg::KIND_RESP;
      r.resp_byte = line_mem[k];
      r.last = (k == n - 1);
      pending_results.push_back(r);
    end
  endfunction

  // update the shadow store with one accepted byte, queue what it causes
  function automatic void track_rx_byte(input logic [7:0] b);
    slr_pkg::result_t fr;
    int n;
    if (line_fill + 1 < slr_pkg::LINE_DEPTH) begin
      line_mem[line_fill] = b;
      line_fill++;
    end
    n = line_fill;
    if (b == slr_pkg::CH_CR) begin
      if (is_frame_head(line_mem[0]) && n > 2) begin
        if (decode_frame(n, fr)) pending_results.push_back(fr);
      end else begin
        echo_line(n);
      end
      line_fill = 0;
    end else if (b == slr_pkg::CH_BEL) begin
      echo_line(n);
      line_fill = 0;
    end
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_q.push_back(s[i]);
  endtask

  // well-formed frame line in line_buf, no terminator; id_digits returned
  task automatic gen_frame_line(output int id_digits);
    int sel, dlc;
    logic [7:0] head;
    sel = $urandom_range(0, 3);
    case (sel)
      0:       head = slr_pkg::CH_STD;
      1:       head = slr_pkg::CH_EXT;
      2:       head = slr_pkg::CH_RSTD;
      default: head = slr_pkg::CH_REXT;
    endcase
    line_buf.delete();
    line_buf.push_back(head);
    id_digits = (head == slr_pkg::CH_EXT || head == slr_pkg::CH_REXT) ? 8 : 3;
    for (int i = 0; i < id_digits; i++) line_buf.push_back(hex_char($urandom_range(0, 15)));
    dlc = $urandom_range(0, 8);
    line_buf.push_back(8'(8'h30 + dlc));
    if (head == slr_pkg::CH_STD || head == slr_pkg::CH_EXT) begin
      for (int i = 0; i < 2 * dlc; i++) line_buf.push_back(hex_char($urandom_range(0, 15)));
    end
    // optional time stamp
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 4; i++) line_buf.push_back(hex_char($urandom_range(0, 15)));
    end
  endtask

  task automatic gen_random_line();
    int pick, id_digits, len, keep;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      gen_frame_line(id_digits);
    end else if (pick < 80) begin
      gen_frame_line(id_digits);
      case ($urandom_range(0, 2))
        0: line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(8'h67, 8'h7E));
        1: line_buf[id_digits + 1] = hex_char($urandom_range(9, 15));
        default: begin
          keep = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > keep) void'(line_buf.pop_back());
        end
      endcase
    end else begin
      line_buf.delete();
      if (pick < 95 || long_lines >= 2) begin
        len = $urandom_range(0, 10);
      end else begin
        len = $urandom_range(60, 75);
        long_lines++;
      end
      for (int i = 0; i < len; i++) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    foreach (line_buf[i]) rx_q.push_back(line_buf[i]);
    rx_q.push_back(($urandom_range(0, 3) == 0) ? slr_pkg::CH_BEL : slr_pkg::CH_CR);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) log_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // sender
  always @(posedge clk) begin : drv
    int g;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) track_rx_byte(in_rx_byte);
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (rx_q.size() > 0) begin
        g = ((sent_cnt / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
        in_valid   <= 1'b1;
        in_rx_byte <= rx_q.pop_front();
        in_gap     <= g;
        sent_cnt   <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : mon
    slr_pkg::result_t want;
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_error($sformatf("unexpected result kind=%0d resp_byte=0x%0h",
                            out_kind, out_resp_byte));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", out_kind, want.kind);
        check_field("frame_id", out_frame_id, want.frame_id);
        check_field("extended", out_extended, want.extended);
        check_field("remote", out_remote, want.remote);
        check_field("dlc", out_dlc, want.dlc);
        check_field("payload", out_payload, want.payload);
        check_field("resp_byte", out_resp_byte, want.resp_byte);
        check_field("last", out_last, want.last);
      end
      res_seen <= res_seen + 1;
      if (!hold_done && res_seen == PRESSURE_AT) begin
        // long hold-off: sender keeps offering, block backs up
        out_wait  <= HOLD_CYCLES;
        out_stall <= 1'b1;
        hold_done <= 1'b1;
      end else begin
        w = ((res_seen / 32) % 3 == 2) ? 0 : $urandom_range(0, 5);
        out_wait  <= w;
        out_stall <= (w != 0);
      end
    end else if (out_wait > 0) begin
      out_wait  <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stim
    // directed lines
    rx_q.push_back(slr_pkg::CH_CR);               // bare CR
    rx_q.push_back(slr_pkg::CH_BEL);              // bare BEL
    rx_q.push_back(slr_pkg::CH_STD);              // frame head too short: echoed
    rx_q.push_back(slr_pkg::CH_CR);
    push_text("tx");                              // bad id digit: dropped
    rx_q.push_back(slr_pkg::CH_CR);
    push_text("R1FFFFFFF8");                      // remote ext, max id, dlc 8
    rx_q.push_back(slr_pkg::CH_CR);
    push_text("t0000");                           // std, zero id, no data
    rx_q.push_back(slr_pkg::CH_CR);
    rx_q.push_back(8'h00);                        // byte extremes, BEL line
    rx_q.push_back(8'hFF);
    rx_q.push_back(slr_pkg::CH_BEL);
    // random lines fill up the total byte count
    while (rx_q.size() < RANDOM_BYTES) gen_random_line();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (rx_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      log_error($sformatf("%0d expected results never arrived", pending_results.size()));

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
